FILE: rtl/block_permutation_192_macros.svh
// assertion macros for the block_permutation_192 design
// included by files that carry concurrent checks, no other dependencies
`ifndef BLOCK_PERMUTATION_192_MACROS_SVH
`define BLOCK_PERMUTATION_192_MACROS_SVH

// same-cycle implication, disabled during reset
`define BP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bp192_pkg.sv
// shared types, constants and mixing functions of the 192-bit permutation
// no dependencies; used by the step unit, the sequencer and the top level
`timescale 1ns / 1ps

package bp192_pkg;

   localparam int HALF_WORDS_DEF = 3;
   localparam int WORD_W         = 32;
   localparam int MAX_ROUNDS     = 13;
   localparam int RND_W          = 4;
   localparam int STEPS          = 10;
   localparam int STEP_W         = 4;
   localparam int RCON_N         = 26;

   // one sub-step of a round, in forward order
   typedef enum logic [STEP_W-1:0] {
      OP_LIN_A,
      OP_LIN_FIRST,
      OP_LIN_SPREAD,
      OP_LIN_LAST,
      OP_LIN_B,
      OP_INJECT,
      OP_ROT_R,
      OP_MIXB_L,
      OP_MIXB_R,
      OP_ROT_L
   } step_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } seq_state_type;

   // control from the sequencer to the datapath
   typedef struct packed {
      logic             load;
      logic             step;
      step_op_type      op;
      logic [RND_W-1:0] rnd;
   } ctl_type;

   // shift amount tables
   localparam logic [4:0] SH_A [16] = '{5'd1, 5'd9, 5'd12, 5'd5, 5'd11, 5'd15, 5'd13, 5'd3,
                                        5'd16, 5'd6, 5'd4, 5'd8, 5'd14, 5'd7, 5'd10, 5'd2};
   localparam logic [4:0] SH_B [16] = '{5'd8, 5'd12, 5'd10, 5'd6, 5'd15, 5'd5, 5'd2, 5'd3,
                                        5'd16, 5'd1, 5'd14, 5'd4, 5'd13, 5'd9, 5'd7, 5'd11};
   localparam logic [4:0] SH_E [16] = '{5'd6, 5'd5, 5'd10, 5'd2, 5'd12, 5'd15, 5'd3, 5'd11,
                                        5'd8, 5'd16, 5'd4, 5'd7, 5'd1, 5'd9, 5'd14, 5'd13};
   localparam logic [4:0] SH_H [16] = '{5'd10, 5'd12, 5'd15, 5'd5, 5'd11, 5'd2, 5'd3, 5'd13,
                                        5'd6, 5'd16, 5'd1, 5'd8, 5'd14, 5'd4, 5'd7, 5'd9};
   localparam logic [4:0] SH_V [16] = '{5'd7, 5'd10, 5'd14, 5'd16, 5'd15, 5'd2, 5'd13, 5'd11,
                                        5'd8, 5'd6, 5'd1, 5'd4, 5'd3, 5'd5, 5'd9, 5'd12};
   localparam logic [4:0] SH_W [16] = '{5'd6, 5'd9, 5'd12, 5'd16, 5'd11, 5'd4, 5'd2, 5'd14,
                                        5'd5, 5'd1, 5'd15, 5'd8, 5'd3, 5'd7, 5'd10, 5'd13};

   // round constants, two per round
   localparam logic [WORD_W-1:0] RCON [RCON_N] = '{
      32'h100cd809, 32'h8cc76981, 32'hbbfdf360, 32'hef5210ad, 32'h14deb5c6, 32'h035e2f35,
      32'h1b5e8771, 32'h527b79bf, 32'h55b5b64c, 32'h463314df, 32'h3aee3d1a, 32'h05221a65,
      32'h9a550a2d, 32'hee3ed3bb, 32'h75e0a6f4, 32'h1d12d04e, 32'h7f895ac6, 32'h86a82676,
      32'h49855833, 32'hf96a8950, 32'h9b15d051, 32'h004381ad, 32'hc58fe08b, 32'ha40763e1,
      32'h29254a93, 32'he4cf79bb};

   // round constant lookup, unused codes read as zero
   function automatic logic [WORD_W-1:0] rcon_at(input logic [RND_W:0] idx);
      logic [WORD_W-1:0] v;
      v = '0;
      if (idx < 5'(RCON_N)) begin
         v = RCON[idx];
      end
      return v;
   endfunction

   // shift-xor diffusion with inverted right term
   function automatic logic [WORD_W-1:0] dif_n(input logic [WORD_W-1:0] x,
                                               input logic [3:0] i);
      logic [WORD_W-1:0] nx;
      nx = ~x;
      return (nx >> SH_V[i]) ^ (x << SH_W[i]) ^ x;
   endfunction

   function automatic logic [WORD_W-1:0] dif_t(input logic [WORD_W-1:0] x,
                                               input logic [4:0] r, input logic [4:0] l);
      return (x >> r) ^ (x << l) ^ x;
   endfunction

   function automatic logic [WORD_W-1:0] dif_p(input logic [WORD_W-1:0] x,
                                               input logic [4:0] r, input logic [4:0] l);
      return (x >> r) ^ (x << l);
   endfunction

endpackage

FILE: rtl/bp192_if.sv
// channel interfaces of the permutation block: request, response, csr write
// depends on nothing
`timescale 1ns / 1ps

interface bp192_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] in_word0;
   logic [31:0] in_word1;
   logic [31:0] in_word2;
   logic [31:0] in_word3;
   logic [31:0] in_word4;
   logic [31:0] in_word5;
   modport source (output valid, opcode, in_word0, in_word1, in_word2, in_word3, in_word4,
                   in_word5, input ready);
   modport sink (input valid, opcode, in_word0, in_word1, in_word2, in_word3, in_word4,
                 in_word5, output ready);
endinterface

interface bp192_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word0;
   logic [31:0] out_word1;
   logic [31:0] out_word2;
   logic [31:0] out_word3;
   logic [31:0] out_word4;
   logic [31:0] out_word5;
   modport source (output valid, out_word0, out_word1, out_word2, out_word3, out_word4,
                   out_word5, input ready);
   modport sink (input valid, out_word0, out_word1, out_word2, out_word3, out_word4,
                 out_word5, output ready);
endinterface

interface bp192_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] round_count;
   modport source (output valid, round_count, input ready);
   modport sink (input valid, round_count, output ready);
endinterface

FILE: rtl/block_permutation_192.sv
// Keyless 192-bit block permutation, forward or inverse, round-iterative.
// Channels: req_if takes an opcode (0 forward, 1 inverse) and six 32-bit words;
// rsp_if returns the six permuted words; csr_if writes the round count
// (0..15, values above 13 saturate to 13, reset value 13), always ready.
// Each round is ten sub-steps (five linear-layer steps, constant injection,
// four Feistel branch steps), executed one per cycle by a single shared step
// unit over the state register under a small sequencer.
// Each request is loaded into the state register, stepped through round_count
// rounds and then offered as the response; zero rounds gives a pass-through
// response the cycle after acceptance. The state register doubles as the
// output register, so a new request is not taken before its predecessor's
// response; it is taken in the same cycle that response is.
// While the receiver stalls the result is held and no request is accepted.
// Reset returns the sequencer to idle and the round count to 13.
// depends on bp192_pkg, bp192_if, bp192_seq, bp192_step_unit and the macros
`timescale 1ns / 1ps
`include "block_permutation_192_macros.svh"

module block_permutation_192 import bp192_pkg::*; #(
   parameter int HALF_WORDS = HALF_WORDS_DEF
) (
   input logic          clock,
   input logic          reset,
   bp192_req_if.sink    req_if,
   bp192_rsp_if.source  rsp_if,
   bp192_csr_if.sink    csr_if
);

   localparam int NW = 2 * HALF_WORDS;

   logic [RND_W-1:0]             rcount_ff, rcount_in;
   logic [NW-1:0][WORD_W-1:0]    words_ff, words_in;
   logic [NW-1:0][WORD_W-1:0]    step_out;
   logic [NW-1:0][WORD_W-1:0]    load_words;
   ctl_type                      ctl;
   logic                         req_ready;
   logic                         rsp_valid;
   logic                         zero_rounds;

   // round count register, saturated on write
   assign csr_if.ready = 1'b1;
   always_comb begin
      rcount_in = rcount_ff;
      if (csr_if.valid) begin
         rcount_in = (csr_if.round_count > RND_W'(MAX_ROUNDS)) ? RND_W'(MAX_ROUNDS)
                                                               : csr_if.round_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcount_ff <= RND_W'(MAX_ROUNDS);
      end else begin
         rcount_ff <= rcount_in;
      end
   end

   // sequencer
   bp192_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_opcode  (req_if.opcode),
      .rsp_ready   (rsp_if.ready),
      .round_count (rcount_ff),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .ctl         (ctl)
   );

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid;

   // shared step unit
   bp192_step_unit #(
      .HALF_WORDS (HALF_WORDS)
   ) u_step (
      .op  (ctl.op),
      .rnd (ctl.rnd),
      .s_i (words_ff),
      .s_o (step_out)
   );

   // incoming block, words past the sixth start at zero
   always_comb begin
      load_words    = '0;
      load_words[0] = req_if.in_word0;
      load_words[1] = req_if.in_word1;
      load_words[2] = req_if.in_word2;
      load_words[3] = req_if.in_word3;
      load_words[4] = req_if.in_word4;
      load_words[5] = req_if.in_word5;
   end

   // state register, also holds the result
   always_comb begin
      words_in = words_ff;
      if (ctl.load) begin
         words_in = load_words;
      end else if (ctl.step) begin
         words_in = step_out;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   assign rsp_if.out_word0 = words_ff[0];
   assign rsp_if.out_word1 = words_ff[1];
   assign rsp_if.out_word2 = words_ff[2];
   assign rsp_if.out_word3 = words_ff[3];
   assign rsp_if.out_word4 = words_ff[4];
   assign rsp_if.out_word5 = words_ff[5];

   // checks
   assign zero_rounds = (rcount_ff == '0);

   `BP_ASSERT_SAME(a_hold_result, clock, reset, rsp_valid, !ctl.step, "result stepped")
   `BP_ASSERT_NEXT(a_rounds_busy, clock, reset, ctl.load && !zero_rounds, !rsp_valid, "early result")
   `BP_ASSERT_NEXT(a_zero_pass, clock, reset, ctl.load && zero_rounds, rsp_valid, "no pass-through")

endmodule

FILE: rtl/bp192_step_unit.sv
// shared round datapath: applies one sub-step of a round to the whole state
// depends on bp192_pkg
`timescale 1ns / 1ps

module bp192_step_unit import bp192_pkg::*; #(
   parameter int HALF_WORDS = HALF_WORDS_DEF
) (
   input  step_op_type                              op,
   input  logic [RND_W-1:0]                         rnd,
   input  logic [2*HALF_WORDS-1:0][WORD_W-1:0]      s_i,
   output logic [2*HALF_WORDS-1:0][WORD_W-1:0]      s_o
);

   localparam int NW = 2 * HALF_WORDS;

   logic [WORD_W-1:0]                    mid;
   logic [HALF_WORDS-1:0][WORD_W-1:0]    mix_src;
   logic [HALF_WORDS-1:0][WORD_W-1:0]    mix_x;
   logic [HALF_WORDS-1:0][WORD_W-1:0]    mix;
   logic [WORD_W-1:0]                    mix_c;
   logic [WORD_W-1:0]                    mix_d;
   logic [WORD_W-1:0]                    sp_c;
   logic [WORD_W-1:0]                    sp_t0;
   logic [WORD_W-1:0]                    sp_t1;

   // xor of the inner words from word 2 to word NW-2
   always_comb begin
      mid = '0;
      for (int i = 2; i <= NW - 2; i++) begin
         mid = mid ^ s_i[i];
      end
   end

   // shared mixb: source half is the right half when it feeds the left
   always_comb begin
      for (int k = 0; k < HALF_WORDS; k++) begin
         mix_src[k] = (op == OP_MIXB_L) ? s_i[HALF_WORDS + k] : s_i[k];
      end
      mix_c = dif_n(mix_src[HALF_WORDS-1], 4'd10) ^ dif_n(mix_src[0], 4'd11);
      mix_d = dif_p(mix_c, SH_V[0], SH_W[0]);
      for (int k = 0; k < HALF_WORDS; k++) begin
         mix_x[k] = mix_src[k] ^ dif_p(mix_d, SH_B[k], SH_H[k]);
      end
      for (int k = 0; k < HALF_WORDS; k++) begin
         mix[k] = ~mix_x[(k + 1 >= HALF_WORDS) ? k + 1 - HALF_WORDS : k + 1]
                  & mix_x[(k + 2 >= HALF_WORDS) ? k + 2 - HALF_WORDS : k + 2];
      end
   end

   // spread terms of the linear layer
   always_comb begin
      sp_c  = dif_n(s_i[0], 4'd4) ^ dif_n(s_i[NW-1], 4'd5);
      sp_t0 = dif_t(sp_c, SH_V[0], SH_W[0]);
      sp_t1 = dif_t(sp_c, SH_V[1], SH_W[1]);
   end

   // sub-step select
   always_comb begin
      s_o = s_i;
      unique case (op)
         OP_LIN_A: begin
            s_o[NW-1] = s_i[NW-1] ^ dif_n(s_i[0], 4'd0);
         end
         OP_LIN_FIRST: begin
            s_o[0] = s_i[0] ^ dif_n(dif_n(s_i[NW-1], 4'd1) ^ dif_n(s_i[1], 4'd2) ^ mid, 4'd3);
         end
         OP_LIN_SPREAD: begin
            for (int k = 1; k <= NW - 2; k++) begin
               s_o[k] = s_i[k] ^ dif_t(((k % 2) == 1) ? sp_t1 : sp_t0,
                                       SH_E[k / 2], SH_A[k / 2]);
            end
         end
         OP_LIN_LAST: begin
            s_o[NW-1] = s_i[NW-1]
                        ^ dif_n(dif_n(s_i[NW-2], 4'd6) ^ dif_n(s_i[0], 4'd7) ^ mid, 4'd8);
         end
         OP_LIN_B: begin
            s_o[0] = s_i[0] ^ dif_n(s_i[NW-1], 4'd9);
         end
         OP_INJECT: begin
            s_o[0]          = s_i[0] ^ rcon_at({rnd, 1'b0});
            s_o[HALF_WORDS] = s_i[HALF_WORDS] ^ WORD_W'(HALF_WORDS) ^ rcon_at({rnd, 1'b1});
         end
         OP_ROT_R: begin
            for (int i = 0; i < HALF_WORDS; i++) begin
               s_o[HALF_WORDS + i] = s_i[HALF_WORDS + i]
                                     ^ s_i[(i + 1 == HALF_WORDS) ? 0 : i + 1];
            end
         end
         OP_MIXB_L: begin
            for (int i = 0; i < HALF_WORDS; i++) begin
               s_o[i] = s_i[i] ^ mix[i];
            end
         end
         OP_MIXB_R: begin
            for (int i = 0; i < HALF_WORDS; i++) begin
               s_o[HALF_WORDS + i] = s_i[HALF_WORDS + i] ^ mix[i];
            end
         end
         OP_ROT_L: begin
            for (int i = 0; i < HALF_WORDS; i++) begin
               s_o[i] = s_i[i] ^ s_i[HALF_WORDS + ((i + 1 == HALF_WORDS) ? 0 : i + 1)];
            end
         end
         default: begin
            s_o = s_i;
         end
      endcase
   end

endmodule

FILE: rtl/bp192_seq.sv
// round sequencer: walks ten sub-steps per round, forward or reversed
// depends on bp192_pkg
`timescale 1ns / 1ps

module bp192_seq import bp192_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_opcode,
   input  logic             rsp_ready,
   input  logic [RND_W-1:0] round_count,
   output logic             req_ready,
   output logic             rsp_valid,
   output ctl_type          ctl
);

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic [RND_W-1:0]  cnt_ff, cnt_in;
   logic              inv_ff, inv_in;
   logic              load;
   logic              last_step;
   logic [STEP_W-1:0] op_idx;

   assign last_step = (step_ff == STEP_W'(STEPS - 1));
   assign load      = req_valid && req_ready;

   // sub-step order is reversed for the inverse
   assign op_idx = inv_ff ? (STEP_W'(STEPS - 1) - step_ff) : step_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (round_count == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_step && cnt_ff == RND_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               if (req_valid) begin
                  state_in = (round_count == '0) ? ST_DONE : ST_RUN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctl.step  = 1'b0;
      ctl.op    = step_op_type'(op_idx);
      ctl.rnd   = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RUN: begin
            ctl.step = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      ctl.load = req_valid && req_ready;
   end

   // step, round and remaining-round counters
   always_comb begin
      step_in = step_ff;
      rnd_in  = rnd_ff;
      cnt_in  = cnt_ff;
      inv_in  = inv_ff;
      if (load) begin
         inv_in  = req_opcode;
         step_in = '0;
         cnt_in  = round_count;
         rnd_in  = req_opcode ? (round_count - RND_W'(1)) : '0;
      end else if (state_ff == ST_RUN) begin
         if (last_step) begin
            step_in = '0;
            cnt_in  = cnt_ff - RND_W'(1);
            rnd_in  = inv_ff ? (rnd_ff - RND_W'(1)) : (rnd_ff + RND_W'(1));
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         rnd_ff   <= '0;
         cnt_ff   <= '0;
         inv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rnd_ff   <= rnd_in;
         cnt_ff   <= cnt_in;
         inv_ff   <= inv_in;
      end
   end

endmodule
